/* rtl/control_token_stripper_assert.svh */
// Assertion macros shared by the control token stripper RTL.
`ifndef CONTROL_TOKEN_STRIPPER_ASSERT_SVH
`define CONTROL_TOKEN_STRIPPER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CTS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CTS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cts_pkg.sv */
// Package: token table, codes and controller/datapath interface types.
`default_nettype none

package cts_pkg;

	localparam int HOLD_DEPTH_DEF = 64;
	localparam int NUM_TOK        = 5;
	localparam int TOK_MAX_LEN    = 19;
	localparam int TOK_POS_W      = 5;
	localparam int TOK_IDX_W      = 3;

	localparam logic       FUNC_DATA  = 1'b0;
	localparam logic       FUNC_FLUSH = 1'b1;
	localparam logic [7:0] OPEN_CHAR  = 8'h3C;
	localparam logic [7:0] CLOSE_CHAR = 8'h3E;

	// Token text, first character in the top byte, zero padded at the bottom.
	localparam logic [TOK_MAX_LEN-1:0][7:0] TOK0 = {"<|begin", "_of_text|>", 16'h0};
	localparam logic [TOK_MAX_LEN-1:0][7:0] TOK1 = {"<|end", "_of_text|>", 32'h0};
	localparam logic [TOK_MAX_LEN-1:0][7:0] TOK2 = {"<|start", "_header_id|>"};
	localparam logic [TOK_MAX_LEN-1:0][7:0] TOK3 = {"<|end", "_header_id|>", 16'h0};
	localparam logic [TOK_MAX_LEN-1:0][7:0] TOK4 = {"<|eot_id|>", 72'h0};

	localparam logic [NUM_TOK-1:0][TOK_MAX_LEN-1:0][7:0] TOK_TEXT =
		{TOK4, TOK3, TOK2, TOK1, TOK0};
	localparam logic [NUM_TOK-1:0][TOK_POS_W-1:0] TOK_LEN =
		{5'd10, 5'd17, 5'd19, 5'd15, 5'd17};

	typedef logic [NUM_TOK-1:0] tok_mask_t;

	// Character of token t at position pos; zero past the table.
	function automatic logic [7:0] tok_char(input logic [TOK_IDX_W-1:0] t,
			input logic [TOK_POS_W-1:0] pos);
		logic [7:0] c;
		c = 8'h00;
		if (pos < TOK_POS_W'(TOK_MAX_LEN))
			c = TOK_TEXT[t][TOK_POS_W'(TOK_MAX_LEN - 1) - pos];
		return c;
	endfunction

	typedef struct packed {
		logic load_item;
		logic hold_append;
		logic hold_open;
		logic clear_hold;
		logic rd_start;
		logic rd_issue;
		logic out_load_held;
		logic out_load_item;
		logic out_last;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_flush;
		logic is_open;
		logic cnt_zero;
		logic prefix_ok;
		logic rd_last;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

/* rtl/cts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

/* rtl/cts_ctrl.sv */
// Controller state machine: sequences evaluate, drain and emit steps.
`default_nettype none
`include "control_token_stripper_assert.svh"

module cts_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output      logic             in_ready,
	input  wire cts_pkg::dp_stat_t stat,
	output      cts_pkg::ctl_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_WAIT = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_EVAL;
				end
			end
			S_EVAL: begin
				if (stat.is_flush) begin
					if (stat.cnt_zero) begin
						state_d = S_IDLE;
					end else begin
						cmd.rd_start = 1'b1;
						state_d      = S_RD;
					end
				end else if (!stat.cnt_zero && stat.prefix_ok) begin
					cmd.hold_append = 1'b1;
					state_d         = S_IDLE;
				end else if (!stat.cnt_zero) begin
					// prefix broken: drain what is held first
					cmd.rd_start = 1'b1;
					state_d      = S_RD;
				end else if (stat.is_open) begin
					cmd.hold_open = 1'b1;
					state_d       = S_IDLE;
				end else if (stat.out_free) begin
					cmd.out_load_item = 1'b1;
					state_d           = S_IDLE;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_RD: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_WAIT;
			end
			S_WAIT: begin
				if (stat.out_free) begin
					cmd.out_load_held = 1'b1;
					cmd.out_last      = stat.rd_last && (stat.is_flush || stat.is_open);
					if (!stat.rd_last) begin
						state_d = S_RD;
					end else if (stat.is_flush) begin
						cmd.clear_hold = 1'b1;
						state_d        = S_IDLE;
					end else if (stat.is_open) begin
						cmd.hold_open = 1'b1;
						state_d       = S_IDLE;
					end else begin
						cmd.clear_hold = 1'b1;
						state_d        = S_EMIT;
					end
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.out_load_item = 1'b1;
					state_d           = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`CTS_ASSERT_NXT(a_rd_then_wait, state_q == S_RD, state_q == S_WAIT,
		"read issue not followed by data wait")
	`CTS_ASSERT_NXT(a_accept_then_eval, cmd.load_item, state_q == S_EVAL,
		"accepted item not evaluated next cycle")
	`CTS_ASSERT_NXT(a_wait_holds, (state_q == S_WAIT) && !stat.out_free,
		state_q == S_WAIT, "held byte dropped while output busy")

endmodule

`default_nettype wire

/* rtl/cts_dpath.sv */
// Datapath: item register, token match tracking, hold buffer and output register.
`default_nettype none
`include "control_token_stripper_assert.svh"

module cts_dpath #(
	parameter int HOLD_DEPTH = cts_pkg::HOLD_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cts_pkg::ctl_cmd_t cmd,
	output      cts_pkg::dp_stat_t stat,
	input  wire logic              func,
	input  wire logic [7:0]        data_byte,
	output      logic              out_valid,
	input  wire logic              out_ready,
	output      logic [7:0]        out_byte,
	output      logic              run_last
);

	localparam int AW = $clog2(HOLD_DEPTH);
	localparam int CW = $clog2(HOLD_DEPTH + 1);

	logic                  func_q;
	logic [7:0]            byte_q;
	logic [CW-1:0]         held_count_q;
	cts_pkg::tok_mask_t    cand_q;
	logic [AW-1:0]         rd_idx_q;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  run_last_q;

	cts_pkg::tok_mask_t    hit;
	logic                  complete;
	logic                  fits;
	logic                  out_free;
	logic [7:0]            ram_rdata;
	logic                  ram_wr_en;
	logic [AW-1:0]         ram_wr_addr;

	// Which candidate tokens still match once byte_q is appended.
	always_comb begin
		hit      = '0;
		complete = 1'b0;
		for (int i = 0; i < cts_pkg::NUM_TOK; i++) begin
			hit[i] = cand_q[i]
				&& (held_count_q < CW'(cts_pkg::TOK_LEN[i]))
				&& (cts_pkg::tok_char(cts_pkg::TOK_IDX_W'(i),
					held_count_q[cts_pkg::TOK_POS_W-1:0]) == byte_q);
			if (hit[i] && (CW'(cts_pkg::TOK_LEN[i]) == held_count_q + CW'(1)))
				complete = 1'b1;
		end
		complete = complete && (byte_q == cts_pkg::CLOSE_CHAR);
	end

	assign fits     = (held_count_q + CW'(1)) < CW'(HOLD_DEPTH);
	assign out_free = !out_valid_q || out_ready;

	assign stat.is_flush  = (func_q == cts_pkg::FUNC_FLUSH);
	assign stat.is_open   = (byte_q == cts_pkg::OPEN_CHAR);
	assign stat.cnt_zero  = (held_count_q == '0);
	assign stat.prefix_ok = fits && (hit != '0);
	assign stat.rd_last   = (CW'(rd_idx_q) + CW'(1)) == held_count_q;
	assign stat.out_free  = out_free;

	assign ram_wr_en   = cmd.hold_append || cmd.hold_open;
	assign ram_wr_addr = cmd.hold_open ? '0 : held_count_q[AW-1:0];

	cts_ram #(
		.WIDTH (8),
		.DEPTH (HOLD_DEPTH)
	) u_hold_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (byte_q),
		.rd_en   (cmd.rd_issue),
		.rd_addr (rd_idx_q),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			func_q <= func;
			byte_q <= data_byte;
		end
		if (cmd.out_load_held) begin
			out_byte_q <= ram_rdata;
			run_last_q <= cmd.out_last;
		end else if (cmd.out_load_item) begin
			out_byte_q <= byte_q;
			run_last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= '0;
			cand_q       <= '0;
			rd_idx_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.hold_open) begin
				held_count_q <= CW'(1);
				cand_q       <= '1;    // every token opens with '<'
			end else if (cmd.hold_append) begin
				held_count_q <= complete ? '0 : held_count_q + CW'(1);
				cand_q       <= hit;
			end else if (cmd.clear_hold) begin
				held_count_q <= '0;
			end
			if (cmd.rd_start)
				rd_idx_q <= '0;
			else if (cmd.out_load_held)
				rd_idx_q <= rd_idx_q + AW'(1);
			if (cmd.out_load_held || cmd.out_load_item)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;

	`CTS_ASSERT_IMP(a_hold_bounded, 1'b1,
		held_count_q <= CW'(cts_pkg::TOK_MAX_LEN), "hold exceeds longest token")
	`CTS_ASSERT_IMP(a_load_when_free, cmd.out_load_held || cmd.out_load_item,
		out_free, "output register overwritten before transfer")
	`CTS_ASSERT_IMP(a_append_nonempty, cmd.hold_append,
		held_count_q != '0, "append with empty hold")

endmodule

`default_nettype wire

/* rtl/control_token_stripper.sv */
// Pass-through byte: accepted, evaluated next cycle, then loaded into the output register once it is free.
// A new item is accepted only in idle, after the previous one is finished; a held prefix
// drains byte by byte (registered hold RAM read, then output load) while the output is free.
// A completed control token or an extended prefix gives no output.
// Asynchronous active-low reset empties the hold and output register; hold RAM not cleared.
`default_nettype none

module control_token_stripper #(
	parameter int HOLD_DEPTH = cts_pkg::HOLD_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_ready,
	input  wire logic       func,
	input  wire logic [7:0] data_byte,
	output      logic       out_valid,
	input  wire logic       out_ready,
	output      logic [7:0] out_byte,
	output      logic       run_last
);

	cts_pkg::ctl_cmd_t cmd;
	cts_pkg::dp_stat_t stat;

	cts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cts_dpath #(
		.HOLD_DEPTH (HOLD_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.func      (func),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

endmodule

`default_nettype wire
